### rtl/core/battery_level_gauge_defines.svh
// assertion macros for the battery level gauge
`ifndef BATTERY_LEVEL_GAUGE_DEFINES_SVH
`define BATTERY_LEVEL_GAUGE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BLG_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BLG_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### rtl/core/blg_pkg.sv
// shared types, constants and helpers for the battery level gauge
package blg_pkg;

    localparam int THR_W      = 12;
    localparam int REG_IDX_W  = 3;
    localparam int DRIVE_W    = 3;
    localparam int LEVEL_W    = 3;
    localparam int MASK_W     = 4;
    localparam int COMP_W     = 6;

    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [MASK_W-1:0]  t_mask;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FULL      = 3'd0,
        REG_THREE_Q   = 3'd1,
        REG_HALF      = 3'd2,
        REG_LOW       = 3'd3,
        REG_EMPTY     = 3'd4,
        REG_OFFSET    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [THR_W-1:0] full;
        logic [THR_W-1:0] three_q;
        logic [THR_W-1:0] half;
        logic [THR_W-1:0] low;
        logic [THR_W-1:0] empty;
    } t_thr;

    typedef struct packed {
        logic [DRIVE_W-1:0] motor_drive;
        logic               charging;
    } t_load;

    localparam logic [THR_W-1:0] FULL_RST    = 12'hCA0;
    localparam logic [THR_W-1:0] THREE_Q_RST = 12'hC40;
    localparam logic [THR_W-1:0] HALF_RST    = 12'hBD0;
    localparam logic [THR_W-1:0] LOW_RST     = 12'hB60;
    localparam logic [THR_W-1:0] EMPTY_RST   = 12'hA00;
    localparam logic [THR_W-1:0] OFFSET_RST  = 12'h080;

    localparam logic [DRIVE_W-1:0] DRIVE_HIGH = 3'd1;
    localparam logic [DRIVE_W-1:0] DRIVE_MID  = 3'd2;
    localparam logic [DRIVE_W-1:0] DRIVE_LOW  = 3'd4;

    localparam logic [COMP_W-1:0] COMP_HIGH = 6'h20;
    localparam logic [COMP_W-1:0] COMP_MID  = 6'h10;
    localparam logic [COMP_W-1:0] COMP_LOW  = 6'h08;
    localparam logic [COMP_W-1:0] COMP_NONE = 6'h00;

    localparam t_level LVL_ZERO  = 3'd0;
    localparam t_level LVL_ONE   = 3'd1;
    localparam t_level LVL_TWO   = 3'd2;
    localparam t_level LVL_THREE = 3'd3;
    localparam t_level LVL_FOUR  = 3'd4;

    function automatic t_mask led_mask(input t_level lvl);
        t_mask m;
        case (lvl)
            LVL_FOUR:  m = 4'hF;
            LVL_THREE: m = 4'h7;
            LVL_TWO:   m = 4'h3;
            LVL_ONE:   m = 4'h1;
            default:   m = 4'h0;
        endcase
        return m;
    endfunction

endpackage

### rtl/core/blg_accum.sv
// window accumulator: running sum and sample count kept in a one-entry state memory
module blg_accum #(
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  logic [SAMPLE_BITS-1:0]                     i_sample,
    input  blg_pkg::t_load                             i_load,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic [SAMPLE_BITS+$clog2(WINDOW)-1:0]      o_sum,
    output blg_pkg::t_load                             o_load
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int SUM_W = SAMPLE_BITS + IDX_W;
    localparam int ST_W  = SUM_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    logic                   r_valid;
    logic [SAMPLE_BITS-1:0] r_sample;
    blg_pkg::t_load         r_load;

    logic [ST_W-1:0]        r_mem [1];
    logic                   r_mem_vld;
    logic [ST_W-1:0]        r_rdata;
    logic                   r_fwd;
    logic [ST_W-1:0]        r_fwd_data;

    logic [ST_W-1:0]        cur_state;
    logic [SUM_W-1:0]       cur_sum;
    logic [IDX_W-1:0]       cur_idx;
    logic [SUM_W-1:0]       new_sum;
    logic                   last;
    logic                   fire;
    logic                   accept;
    logic [ST_W-1:0]        wdata;

    assign cur_state = r_fwd ? r_fwd_data : r_rdata;
    assign cur_sum   = cur_state[ST_W-1 -: SUM_W];
    assign cur_idx   = cur_state[IDX_W-1:0];
    assign new_sum   = cur_sum + SUM_W'(r_sample);
    assign last      = (cur_idx == LAST_IDX);
    assign wdata     = last ? '0 : {new_sum, cur_idx + IDX_W'(1)};

    assign fire    = r_valid && (!last || i_ready);
    assign o_stall = r_valid && !fire;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid && last;
    assign o_sum   = new_sum;
    assign o_load  = r_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_mem_vld <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_fwd   <= fire;
            end else if (fire) begin
                r_valid <= 1'b0;
            end
            if (fire) begin
                r_mem_vld <= 1'b1;
            end
        end
    end

    // state memory: read on accept, write back when the word leaves
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample   <= i_sample;
            r_load     <= i_load;
            r_rdata    <= r_mem_vld ? r_mem[0] : '0;
            r_fwd_data <= wdata;
        end
        if (fire) begin
            r_mem[0] <= wdata;
        end
    end

endmodule

### rtl/core/blg_scale.sv
// window average by reciprocal multiply, load compensation and charge offset
module blg_scale #(
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_valid,
    output logic                                              o_ready,
    input  logic [SAMPLE_BITS+$clog2(WINDOW)-1:0]             i_sum,
    input  blg_pkg::t_load                                    i_load,
    input  logic [blg_pkg::THR_W-1:0]                         i_charge_offset,
    output logic                                              o_valid,
    input  logic                                              i_ready,
    output logic [(SAMPLE_BITS > 12 ? SAMPLE_BITS : 12):0]    o_value
);

    localparam int LOG_W  = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_BITS + LOG_W;
    localparam int RCP_W  = SUM_W + 1;
    localparam int SHIFT  = SUM_W + LOG_W;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam int VAL_W  = (SAMPLE_BITS > 12 ? SAMPLE_BITS : 12) + 1;
    localparam longint unsigned RCP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

    logic                           r_a_valid;
    logic [SUM_W-1:0]               r_a_sum;
    blg_pkg::t_load                 r_a_load;
    logic                           r_b_valid;
    logic [SAMPLE_BITS-1:0]         r_b_avg;
    blg_pkg::t_load                 r_b_load;
    logic                           r_c_valid;
    logic [VAL_W-1:0]               r_c_value;

    logic                           a_ready;
    logic                           b_ready;
    logic                           c_ready;
    logic [PROD_W-1:0]              prod;
    logic [blg_pkg::COMP_W-1:0]     comp;
    logic [VAL_W-1:0]               comp_value;
    logic [VAL_W-1:0]               offset_ext;
    logic [VAL_W-1:0]               value;

    assign c_ready = !r_c_valid || i_ready;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_c_valid;
    assign o_value = r_c_value;

    assign prod = PROD_W'(r_a_sum) * PROD_W'(RCP);

    always_comb begin
        case (r_b_load.motor_drive)
            blg_pkg::DRIVE_HIGH: comp = blg_pkg::COMP_HIGH;
            blg_pkg::DRIVE_MID:  comp = blg_pkg::COMP_MID;
            blg_pkg::DRIVE_LOW:  comp = blg_pkg::COMP_LOW;
            default:             comp = blg_pkg::COMP_NONE;
        endcase
        comp_value = VAL_W'(r_b_avg) + VAL_W'(comp);
        offset_ext = VAL_W'(i_charge_offset);
        if (r_b_load.charging) begin
            value = (comp_value > offset_ext) ? comp_value - offset_ext : '0;
        end else begin
            value = comp_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_sum  <= i_sum;
            r_a_load <= i_load;
        end
        if (b_ready && r_a_valid) begin
            r_b_avg  <= prod[SHIFT +: SAMPLE_BITS];
            r_b_load <= r_a_load;
        end
        if (c_ready && r_b_valid) begin
            r_c_value <= value;
        end
    end

endmodule

### rtl/core/blg_cls.sv
// level classifier with held level memory and output register
module blg_cls #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_valid,
    output logic                                              o_ready,
    input  logic [(SAMPLE_BITS > 12 ? SAMPLE_BITS : 12):0]    i_value,
    input  blg_pkg::t_thr                                     i_thr,
    output logic                                              o_valid,
    input  logic                                              i_stall,
    output blg_pkg::t_level                                   o_level,
    output blg_pkg::t_mask                                    o_led_mask
);

    localparam int VAL_W = (SAMPLE_BITS > 12 ? SAMPLE_BITS : 12) + 1;

    logic               r_d_valid;
    logic [VAL_W-1:0]   r_d_value;
    blg_pkg::t_level    r_mem [1];
    logic               r_mem_vld;
    blg_pkg::t_level    r_rdata;
    logic               r_fwd;
    blg_pkg::t_level    r_fwd_lvl;
    logic               r_o_valid;
    blg_pkg::t_level    r_o_level;
    blg_pkg::t_mask     r_o_mask;

    logic               out_ready;
    logic               d_ready;
    logic               d_load;
    logic               d_fire;
    blg_pkg::t_level    held;
    blg_pkg::t_level    lvl;

    assign out_ready  = !r_o_valid || !i_stall;
    assign d_ready    = !r_d_valid || out_ready;
    assign d_fire     = r_d_valid && out_ready;
    assign d_load     = i_valid && d_ready;
    assign o_ready    = d_ready;
    assign o_valid    = r_o_valid;
    assign o_level    = r_o_level;
    assign o_led_mask = r_o_mask;

    assign held = r_fwd ? r_fwd_lvl : r_rdata;

    always_comb begin
        if (r_d_value > VAL_W'(i_thr.full)) begin
            lvl = blg_pkg::LVL_FOUR;
        end else if (r_d_value > VAL_W'(i_thr.three_q)) begin
            lvl = blg_pkg::LVL_THREE;
        end else if (r_d_value > VAL_W'(i_thr.half)) begin
            lvl = blg_pkg::LVL_TWO;
        end else if (r_d_value > VAL_W'(i_thr.low)) begin
            lvl = blg_pkg::LVL_ONE;
        end else if (r_d_value < VAL_W'(i_thr.empty)) begin
            lvl = blg_pkg::LVL_ZERO;
        end else begin
            lvl = held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_mem_vld <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            if (d_ready) begin
                r_d_valid <= i_valid;
            end
            if (out_ready) begin
                r_o_valid <= r_d_valid;
            end
            if (d_fire) begin
                r_mem_vld <= 1'b1;
            end
            if (d_load) begin
                r_fwd <= d_fire;
            end
        end
    end

    // held level: read as a word enters, written back as it leaves
    always_ff @(posedge i_clk) begin
        if (d_load) begin
            r_d_value <= i_value;
            r_rdata   <= r_mem_vld ? r_mem[0] : blg_pkg::LVL_ZERO;
            r_fwd_lvl <= lvl;
        end
        if (d_fire) begin
            r_mem[0]  <= lvl;
            r_o_level <= lvl;
            r_o_mask  <= blg_pkg::led_mask(lvl);
        end
    end

endmodule

### rtl/core/battery_level_gauge.sv
// battery level gauge top level: configuration registers and pipeline
//
//  word      | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------------
//  sample    | in        | i_valid / o_stall  | i_sample, i_motor_drive, i_charging
//  level     | out       | o_valid / i_stall  | o_level, o_led_mask
//  config    | in        | i_cfg_wr_en        | i_cfg_index, i_cfg_wdata
//
// one sample per cycle unless stalled; window state is read and written back once per word
// a window's level word leaves via scaler registers a, b, c and classifier registers d and o
// synchronous reset clears the window sum, the count and the held level (level zero)
// output stall backs up through the stage registers; input stalls only once they are full
`include "battery_level_gauge_defines.svh"

module battery_level_gauge #(
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [SAMPLE_BITS-1:0]            i_sample,
    input  logic [blg_pkg::DRIVE_W-1:0]       i_motor_drive,
    input  logic                              i_charging,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [blg_pkg::LEVEL_W-1:0]       o_level,
    output logic [blg_pkg::MASK_W-1:0]        o_led_mask,
    input  logic                              i_cfg_wr_en,
    input  logic [blg_pkg::REG_IDX_W-1:0]     i_cfg_index,
    input  logic [blg_pkg::THR_W-1:0]         i_cfg_wdata
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
    localparam int VAL_W = (SAMPLE_BITS > 12 ? SAMPLE_BITS : 12) + 1;

    blg_pkg::t_thr              r_thr;
    logic [blg_pkg::THR_W-1:0]  r_charge_offset;

    blg_pkg::t_load             in_load;
    logic                       w_acc_valid;
    logic                       w_scale_ready;
    logic [SUM_W-1:0]           w_sum;
    blg_pkg::t_load             w_load;
    logic                       w_val_valid;
    logic                       w_cls_ready;
    logic [VAL_W-1:0]           w_value;

    assign in_load.motor_drive = i_motor_drive;
    assign in_load.charging    = i_charging;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.full      <= blg_pkg::FULL_RST;
            r_thr.three_q   <= blg_pkg::THREE_Q_RST;
            r_thr.half      <= blg_pkg::HALF_RST;
            r_thr.low       <= blg_pkg::LOW_RST;
            r_thr.empty     <= blg_pkg::EMPTY_RST;
            r_charge_offset <= blg_pkg::OFFSET_RST;
        end else if (i_cfg_wr_en) begin
            unique case (blg_pkg::t_reg_idx'(i_cfg_index))
                blg_pkg::REG_FULL:    r_thr.full      <= i_cfg_wdata;
                blg_pkg::REG_THREE_Q: r_thr.three_q   <= i_cfg_wdata;
                blg_pkg::REG_HALF:    r_thr.half      <= i_cfg_wdata;
                blg_pkg::REG_LOW:     r_thr.low       <= i_cfg_wdata;
                blg_pkg::REG_EMPTY:   r_thr.empty     <= i_cfg_wdata;
                blg_pkg::REG_OFFSET:  r_charge_offset <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    blg_accum #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_sample (i_sample),
        .i_load   (in_load),
        .o_valid  (w_acc_valid),
        .i_ready  (w_scale_ready),
        .o_sum    (w_sum),
        .o_load   (w_load)
    );

    blg_scale #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_acc_valid),
        .o_ready         (w_scale_ready),
        .i_sum           (w_sum),
        .i_load          (w_load),
        .i_charge_offset (r_charge_offset),
        .o_valid         (w_val_valid),
        .i_ready         (w_cls_ready),
        .o_value         (w_value)
    );

    blg_cls #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cls (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_val_valid),
        .o_ready    (w_cls_ready),
        .i_value    (w_value),
        .i_thr      (r_thr),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_level    (o_level),
        .o_led_mask (o_led_mask)
    );

    // input only backs up behind a finished window the scaler cannot take
    `BLG_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, w_acc_valid && !w_scale_ready, "input stalled without a blocked window")
    // a blocked window stays offered
    `BLG_ASSERT_NEXT(a_window_held, i_clk, i_rst_n, w_acc_valid && !w_scale_ready, w_acc_valid, "finished window dropped")
    // led mask agrees with the level shown
    `BLG_ASSERT_NOW(a_mask_match, i_clk, i_rst_n, o_valid, o_led_mask == blg_pkg::led_mask(o_level), "led mask does not match level")

endmodule
